// ----- src/matrix_multiply_assert.svh -----
// Assertion macros for the matrix multiply block.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef MATRIX_MULTIPLY_ASSERT_SVH
`define MATRIX_MULTIPLY_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define MM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define MM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/mm_pkg.sv -----
// Shared types and constants of the matrix multiply block.
// No dependencies; used by the channel interfaces and the top level.
package mm_pkg;

  // Defaults of the top-level parameters
  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int REQ_W     = 2;
  localparam int POS_W     = 3;
  localparam int VALUE_W   = 32;
  localparam int SIZE_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int PROD_W    = 2 * VALUE_W;
  // Eight full-scale products reach 2^65, so keep three guard bits
  localparam int ACC_W     = PROD_W + 3;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD_A  = 2'd0,
    REQ_LOAD_B  = 2'd1,
    REQ_COMPUTE = 2'd2
  } req_type_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

endpackage

// ----- src/mm_if.sv -----
// Valid/ready channels of the matrix multiply block: request words in,
// product words out. Depends on mm_pkg for the field widths.
interface mm_req_if import mm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [POS_W-1:0]   elem_row;
  logic [POS_W-1:0]   elem_col;
  logic signed [VALUE_W-1:0] elem_value;

  modport source (output valid, req_type, elem_row, elem_col, elem_value, input ready);
  modport sink   (input valid, req_type, elem_row, elem_col, elem_value, output ready);
endinterface

interface mm_prod_if import mm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   out_row;
  logic [POS_W-1:0]   out_col;
  logic signed [VALUE_W-1:0] out_value;
  logic               saturated;
  logic               last;

  modport source (output valid, out_row, out_col, out_value, saturated, last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, saturated, last, output ready);
endinterface

// ----- src/mm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/matrix_multiply.sv -----
// Matrix multiply top level: element stores, multiply-accumulate sequencer
// and output register. Depends on mm_pkg, mm_if, mm_ram and the assert header.
//
// Load words (A or B element) are taken one per cycle and written straight into
// one of two element memories; loads outside the configured sizes are dropped.
// A compute word holds off input until every product element has been handed to
// the output register, in row-major order with last set on the final one. Each
// product element passes through one multiply-accumulate step a cycle in the
// single 32x32 multiplier fed by one read port of each memory, a drain through
// the memory read registers and the product register, a step that sees the sum
// complete and one that hands it to the output register; a stalled output adds
// its wait. Sums are exact, shifted right by FRAC_BITS with floor rounding and
// clamped to the signed 32-bit range. Memory contents are undefined until loaded;
// there is no clearing pass after reset. Configure only while the block is idle.
module matrix_multiply import mm_pkg::*; #(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  mm_req_if.sink               req,
  mm_prod_if.source            prod
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_DIM);
  localparam logic signed [PROD_W-1:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [PROD_W-1:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;

  // Configuration registers
  logic [SIZE_W-1:0] rows_a, inner_size, cols_b;
  logic [DIM_W-1:0]  m_eff, n_eff, p_eff;

  // Sequencer counters
  logic [IDX_W-1:0] i_cnt, j_cnt;
  logic [DIM_W-1:0] k_cnt;

  // Memory ports
  logic              a_we, b_we;
  logic [ADDR_W-1:0] load_addr, a_raddr, b_raddr;
  logic [VALUE_W-1:0] a_rdata, b_rdata;

  // Multiply-accumulate pipeline
  logic                      issue, v1, v2;
  logic signed [PROD_W-1:0]  product;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   acc_shift;
  logic signed [ACC_W-1:0]   sum;
  logic                      elem_done, out_free, row_end, col_end;
  logic                      take;

  // Output register
  logic                      out_valid;
  logic [POS_W-1:0]          out_row, out_col;
  logic signed [VALUE_W-1:0] out_value;
  logic                      out_sat, out_last;

  // Clamp sizes above the store dimension
  assign m_eff = DIM_W'((rows_a     > MAX_SIZE) ? MAX_SIZE : rows_a);
  assign n_eff = DIM_W'((inner_size > MAX_SIZE) ? MAX_SIZE : inner_size);
  assign p_eff = DIM_W'((cols_b     > MAX_SIZE) ? MAX_SIZE : cols_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= SIZE_RESET;
      inner_size <= SIZE_RESET;
      cols_b     <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A:     rows_a     <= cfg_data;
        REG_INNER_SIZE: inner_size <= cfg_data;
        REG_COLS_B:     cols_b     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept words only between products
  assign req.ready = (state == ST_IDLE);
  assign take      = req.valid && req.ready;

  // Load decode; writes happen only in idle and read data is used only outside it
  always_comb begin
    a_we = 1'b0;
    b_we = 1'b0;
    if (take) begin
      case (req.req_type)
        REQ_LOAD_A:
          a_we = ({1'b0, req.elem_row} < SIZE_W'(m_eff)) &&
                 ({1'b0, req.elem_col} < SIZE_W'(n_eff));
        REQ_LOAD_B:
          b_we = ({1'b0, req.elem_row} < SIZE_W'(n_eff)) &&
                 ({1'b0, req.elem_col} < SIZE_W'(p_eff));
        default: ;
      endcase
    end
  end

  assign load_addr = ADDR_W'(int'(req.elem_row) * MAX_DIM + int'(req.elem_col));
  assign a_raddr   = ADDR_W'(int'(i_cnt) * MAX_DIM + int'(k_cnt));
  assign b_raddr   = ADDR_W'(int'(k_cnt) * MAX_DIM + int'(j_cnt));

  mm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (load_addr),
    .wdata (req.elem_value),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  mm_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (load_addr),
    .wdata (req.elem_value),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // Issue one pair of reads a cycle until the inner sum is covered
  assign issue     = (state == ST_RUN) && (k_cnt != n_eff);
  assign elem_done = (state == ST_RUN) && (k_cnt == n_eff) && !v1 && !v2;
  assign out_free  = !out_valid || prod.ready;
  assign col_end   = (DIM_W'(j_cnt) + 1'b1) == p_eff;
  assign row_end   = (DIM_W'(i_cnt) + 1'b1) == m_eff;

  // Floor shift of the exact sum, kept at full width for the clamp
  assign acc_shift = acc >>> FRAC_BITS;
  assign sum       = acc_shift;

  // Multiply, then accumulate the exact product
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
    end
    product <= $signed(a_rdata) * $signed(b_rdata);
    if (state == ST_IDLE || (state == ST_EMIT && out_free)) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(product);
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          i_cnt <= '0;
          j_cnt <= '0;
          k_cnt <= '0;
          if (take && req.req_type == REQ_COMPUTE && m_eff != '0 && p_eff != '0) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (issue) begin
            k_cnt <= k_cnt + 1'b1;
          end
          if (elem_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            k_cnt <= '0;
            if (col_end) begin
              j_cnt <= '0;
              i_cnt <= i_cnt + 1'b1;
            end else begin
              j_cnt <= j_cnt + 1'b1;
            end
            state <= (col_end && row_end) ? ST_IDLE : ST_RUN;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register: load a finished element, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (prod.ready) begin
      out_valid <= 1'b0;
    end
    if (state == ST_EMIT && out_free) begin
      out_row  <= POS_W'(i_cnt);
      out_col  <= POS_W'(j_cnt);
      out_last <= col_end && row_end;
      if (sum > SAT_HI) begin
        out_value <= SAT_HI[VALUE_W-1:0];
        out_sat   <= 1'b1;
      end else if (sum < SAT_LO) begin
        out_value <= SAT_LO[VALUE_W-1:0];
        out_sat   <= 1'b1;
      end else begin
        out_value <= sum[VALUE_W-1:0];
        out_sat   <= 1'b0;
      end
    end
  end

  assign prod.valid     = out_valid;
  assign prod.out_row   = out_row;
  assign prod.out_col   = out_col;
  assign prod.out_value = out_value;
  assign prod.saturated = out_sat;
  assign prod.last      = out_last;

`include "matrix_multiply_assert.svh"

  `MM_ASSERT_IMPL(a_k_bound, state == ST_RUN, k_cnt <= n_eff, "inner counter past inner size")
  `MM_ASSERT_IMPL(a_drained, state == ST_EMIT, !v1 && !v2, "result formed before pipeline drained")
  `MM_ASSERT_NEXT(a_emit_loads, state == ST_EMIT && out_free, out_valid, "finished element not loaded")
  `MM_ASSERT_NEXT(a_issue_flow, issue, v1, "issued read lost in pipeline")

endmodule

// ----- tb/mm_product_checker.sv -----
`timescale 1ns / 1ps
// Product checker for matrix_multiply: mirrors the element stores and sizes,
// predicts every product word and compares it with the words the block emits.
// Depends on mm_pkg and the channel interfaces of mm_if.
module mm_product_checker import mm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data,
  mm_req_if                    req,
  mm_prod_if                   prod,
  output int unsigned          fail_count,
  output int unsigned          pending
);

  // Wide enough for eight exact 64-bit products without wrap
  localparam int SUM_W = 72;
  localparam logic signed [SUM_W-1:0] Q_MAX = 72'sh7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] Q_MIN = -72'sh8000_0000;

  typedef struct packed {
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [VALUE_W-1:0] value;
    logic               saturated;
    logic               last;
  } prod_word_t;

  logic signed [VALUE_W-1:0] a_elem [MAX_DIM_DEF][MAX_DIM_DEF];
  logic signed [VALUE_W-1:0] b_elem [MAX_DIM_DEF][MAX_DIM_DEF];
  logic [SIZE_W-1:0]         rows_sz, inner_sz, cols_sz;
  prod_word_t                expected_products [$];
  int unsigned               mismatches;

  // Size register as the block sees it: anything above the maximum is the maximum
  function automatic int unsigned dim_of(logic [SIZE_W-1:0] v);
    return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(v);
  endfunction

  // One product element: exact sum, floor shift, clamp to Q16.16
  function automatic prod_word_t product_element(int unsigned i, int unsigned j,
                                                 int unsigned n, bit is_last);
    logic signed [SUM_W-1:0] sum, scaled, a_x, b_x;
    prod_word_t w;
    sum = '0;
    for (int unsigned k = 0; k < n; k++) begin
      a_x = a_elem[i][k];
      b_x = b_elem[k][j];
      sum = sum + a_x * b_x;
    end
    scaled = sum >>> FRAC_BITS_DEF;
    w.row  = POS_W'(i);
    w.col  = POS_W'(j);
    w.last = is_last;
    if (scaled > Q_MAX) begin
      w.value     = 32'h7FFF_FFFF;
      w.saturated = 1'b1;
    end else if (scaled < Q_MIN) begin
      w.value     = 32'h8000_0000;
      w.saturated = 1'b1;
    end else begin
      w.value     = scaled[VALUE_W-1:0];
      w.saturated = 1'b0;
    end
    return w;
  endfunction

  always @(posedge clk) begin : track
    int unsigned m, n, p;
    prod_word_t  want;
    m = dim_of(rows_sz);
    n = dim_of(inner_sz);
    p = dim_of(cols_sz);
    if (rst) begin
      rows_sz  = SIZE_RESET;
      inner_sz = SIZE_RESET;
      cols_sz  = SIZE_RESET;
      expected_products.delete();
    end else begin
      // Compare an accepted product word with the oldest prediction
      if (prod.valid && prod.ready) begin
        if (expected_products.size() == 0) begin
          $error("product word with nothing expected: row %0d col %0d value %0d",
                 prod.out_row, prod.out_col, prod.out_value);
          mismatches++;
        end else begin
          want = expected_products.pop_front();
          if (prod.out_row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, prod.out_row);
            mismatches++;
          end
          if (prod.out_col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, prod.out_col);
            mismatches++;
          end
          if (prod.out_value !== want.value) begin
            $error("out_value: expected %0d, got %0d",
                   $signed(want.value), prod.out_value);
            mismatches++;
          end
          if (prod.saturated !== want.saturated) begin
            $error("saturated: expected %0d, got %0d", want.saturated, prod.saturated);
            mismatches++;
          end
          if (prod.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, prod.last);
            mismatches++;
          end
        end
      end

      // Apply an accepted request word to the mirrored stores
      if (req.valid && req.ready) begin
        case (req.req_type)
          REQ_LOAD_A: begin
            if (req.elem_row < m && req.elem_col < n)
              a_elem[req.elem_row][req.elem_col] = req.elem_value;
          end
          REQ_LOAD_B: begin
            if (req.elem_row < n && req.elem_col < p)
              b_elem[req.elem_row][req.elem_col] = req.elem_value;
          end
          REQ_COMPUTE: begin
            for (int unsigned i = 0; i < m; i++)
              for (int unsigned j = 0; j < p; j++)
                expected_products.push_back(
                  product_element(i, j, n, (i == m - 1) && (j == p - 1)));
          end
          default: ;
        endcase
      end

      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_ROWS_A:     rows_sz  = cfg_data;
          REG_INNER_SIZE: inner_sz = cfg_data;
          REG_COLS_B:     cols_sz  = cfg_data;
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    pending    <= expected_products.size();
  end

endmodule

// ----- tb/tb_matrix_multiply.sv -----
`timescale 1ns / 1ps
// Testbench top for matrix_multiply: clock, reset, size writes, request words,
// product back-pressure, watchdog and verdict.
// Depends on mm_pkg, mm_if, matrix_multiply and mm_product_checker.
module tb_matrix_multiply;
  import mm_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned ITEM_TARGET   = 310;
  localparam int unsigned CALM_ITEMS    = 40;
  // Leave a margin past the longest element
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned LONG_HOLD     = 600;
  // Worst quiet stretch: long hold plus one element plus a stall burst, many times over
  localparam int unsigned IDLE_LIMIT    = 4000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIZE_W-1:0]    cfg_data;
  int unsigned          fail_count, pending;

  mm_req_if  req_ch ();
  mm_prod_if prod_ch ();

  matrix_multiply dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .prod      (prod_ch)
  );

  mm_product_checker prod_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req_ch),
    .prod       (prod_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus-side view of the sizes and of which entries hold data
  logic [SIZE_W-1:0] sz_rows = SIZE_RESET;
  logic [SIZE_W-1:0] sz_inner = SIZE_RESET;
  logic [SIZE_W-1:0] sz_cols = SIZE_RESET;
  bit                a_loaded [MAX_DIM_DEF][MAX_DIM_DEF];
  bit                b_loaded [MAX_DIM_DEF][MAX_DIM_DEF];
  int unsigned       items_done;
  bit                calm;
  int unsigned       gap_pct = 20;
  int unsigned       stall_pct = 10;
  bit                long_hold_go;
  int unsigned       idle_cycles;

  function automatic int unsigned dim_of(logic [SIZE_W-1:0] v);
    return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(v);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4, 5: return $urandom;
      default: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    endcase
  endfunction

  // Mostly small sizes, now and then empty, full or oversized
  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 19))
      0:       return 4'd0;
      1:       return 4'd8;
      2:       return SIZE_W'($urandom_range(9, 15));
      default: return SIZE_W'($urandom_range(1, 3));
    endcase
  endfunction

  // Offer one request word and hold it until accepted
  task automatic send_word(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] r,
                           input logic [POS_W-1:0] c, input logic [VALUE_W-1:0] v);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.elem_row   <= r;
    req_ch.elem_col   <= c;
    req_ch.elem_value <= v;
    do @(posedge clk); while (!req_ch.ready);
    if (kind == REQ_LOAD_A && r < dim_of(sz_rows) && c < dim_of(sz_inner)) begin
      a_loaded[r][c] = 1'b1;
      items_done++;
    end else if (kind == REQ_LOAD_B && r < dim_of(sz_inner) && c < dim_of(sz_cols)) begin
      b_loaded[r][c] = 1'b1;
      items_done++;
    end else if (kind == REQ_COMPUTE) begin
      items_done++;
    end
  endtask

  // Write all three size registers back to back
  task automatic write_sizes(input logic [SIZE_W-1:0] rows, input logic [SIZE_W-1:0] inner,
                             input logic [SIZE_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS_A;
    cfg_data  <= rows;
    @(posedge clk);
    cfg_index <= REG_INNER_SIZE;
    cfg_data  <= inner;
    @(posedge clk);
    cfg_index <= REG_COLS_B;
    cfg_data  <= cols;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sz_rows  = rows;
    sz_inner = inner;
    sz_cols  = cols;
  endtask

  // Drop valid, wait for every product word, then let the block go quiet
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1))
      send_word(REQ_UNUSED, POS_W'($urandom), POS_W'($urandom), $urandom);
    else
      send_word($urandom_range(0, 1) ? REQ_LOAD_A : REQ_LOAD_B,
                POS_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)), rand_value());
  endtask

  // In-range load of a random A or B entry; noise instead when its size is zero
  task automatic send_operand();
    int unsigned      lim_r, lim_c;
    logic [REQ_W-1:0] kind;
    if ($urandom_range(0, 1)) begin
      kind  = REQ_LOAD_A;
      lim_r = dim_of(sz_rows);
      lim_c = dim_of(sz_inner);
    end else begin
      kind  = REQ_LOAD_B;
      lim_r = dim_of(sz_inner);
      lim_c = dim_of(sz_cols);
    end
    if (lim_r == 0 || lim_c == 0)
      send_noise();
    else
      send_word(kind, POS_W'($urandom_range(0, lim_r - 1)),
                POS_W'($urandom_range(0, lim_c - 1)), rand_value());
  endtask

  // Load each unloaded operand entry the product will read, then ask for the product
  task automatic run_product();
    for (int i = 0; i < dim_of(sz_rows); i++)
      for (int k = 0; k < dim_of(sz_inner); k++)
        if (!a_loaded[i][k]) send_word(REQ_LOAD_A, POS_W'(i), POS_W'(k), rand_value());
    for (int k = 0; k < dim_of(sz_inner); k++)
      for (int j = 0; j < dim_of(sz_cols); j++)
        if (!b_loaded[k][j]) send_word(REQ_LOAD_B, POS_W'(k), POS_W'(j), rand_value());
    send_word(REQ_COMPUTE, POS_W'($urandom), POS_W'($urandom), $urandom);
  endtask

  initial begin : stimulus
    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_ROWS_A;
    cfg_data          <= SIZE_RESET;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_LOAD_A;
    req_ch.elem_row   <= '0;
    req_ch.elem_col   <= '0;
    req_ch.elem_value <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Full-scale operands: every sum leaves the Q16.16 range, one pair reaches 2^63
    write_sizes(4'd2, 4'd2, 4'd2);
    send_word(REQ_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_word(REQ_LOAD_A, 3'd0, 3'd1, 32'h7FFF_FFFF);
    send_word(REQ_LOAD_A, 3'd1, 3'd0, 32'h8000_0000);
    send_word(REQ_LOAD_A, 3'd1, 3'd1, 32'h8000_0000);
    send_word(REQ_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
    send_word(REQ_LOAD_B, 3'd1, 3'd0, 32'h7FFF_FFFF);
    send_word(REQ_LOAD_B, 3'd0, 3'd1, 32'h8000_0000);
    send_word(REQ_LOAD_B, 3'd1, 3'd1, 32'h8000_0000);
    // Out-of-range loads and the unused request code change nothing
    send_word(REQ_LOAD_A, 3'd2, 3'd0, 32'h1234_5678);
    send_word(REQ_LOAD_B, 3'd0, 3'd7, 32'hFFFF_FFFF);
    send_word(REQ_LOAD_A, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_word(REQ_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
    send_word(REQ_UNUSED, 3'd0, 3'd0, 32'h0000_0000);
    send_word(REQ_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF);
    // Floor rounding of tiny products, negative and positive, in the first row
    send_word(REQ_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF);
    send_word(REQ_LOAD_A, 3'd0, 3'd1, 32'h0000_0000);
    send_word(REQ_LOAD_A, 3'd1, 3'd0, 32'h0001_8000);
    send_word(REQ_LOAD_B, 3'd0, 3'd0, 32'h0000_0001);
    send_word(REQ_LOAD_B, 3'd0, 3'd1, 32'hFFFF_0000);
    send_word(REQ_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);
    settle();

    // Empty product
    write_sizes(4'd0, 4'd2, 4'd2);
    send_word(REQ_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);
    settle();
    // Zero inner size gives all-zero sums
    write_sizes(4'd2, 4'd0, 4'd2);
    send_word(REQ_COMPUTE, 3'd0, 3'd0, 32'h0000_0000);
    settle();
    // Oversized registers act as the full dimension
    write_sizes(4'd15, 4'd1, 4'd9);
    run_product();
    settle();

    // Hold the product side for a long stretch while requests keep coming
    write_sizes(4'd8, 4'd2, 4'd8);
    gap_pct      = 0;
    long_hold_go = 1'b1;
    run_product();
    repeat (8) send_operand();
    run_product();
    settle();

    // Random phases: mostly well-formed load and product sequences
    while (items_done < ITEM_TARGET) begin
      if (items_done + CALM_ITEMS >= ITEM_TARGET) calm = 1'b1;
      case ($urandom_range(0, 2))
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 15;
          stall_pct = 8;
        end
        default: begin
          gap_pct   = 40;
          stall_pct = 25;
        end
      endcase
      write_sizes(pick_size(), pick_size(), pick_size());
      repeat ($urandom_range(3, 12)) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: send_operand();
          6, 7:             run_product();
          default:          send_noise();
        endcase
      end
      run_product();
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Product-side ready: random stall bursts, one long hold on request
  initial begin : product_backpressure
    prod_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (long_hold_go) begin
        prod_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_go = 1'b0;
        prod_ch.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        prod_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
        prod_ch.ready <= 1'b1;
      end else begin
        prod_ch.ready <= 1'b1;
      end
    end
  end

  // End the run when no word moves on either channel for too long
  always @(posedge clk) begin : watchdog
    if (rst || (req_ch.valid && req_ch.ready) || (prod_ch.valid && prod_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
